FILE: sv/servo_frame_parser_crc16_core_assert.svh
// ----------------------------------------------------------------------------
// servo frame parser assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SERVO_FRAME_PARSER_CRC16_CORE_ASSERT_SVH
`define SERVO_FRAME_PARSER_CRC16_CORE_ASSERT_SVH

// implication within the same cycle
`define SFP_ASSERT_SAME(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication in the next cycle
`define SFP_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// constants, types and the crc step shared by the servo frame parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfp_pkg;

	typedef logic [7:0]  sfp_byte_t;
	typedef logic [15:0] sfp_word_t;

	localparam sfp_byte_t SYNC_BYTE    = 8'hA1;
	localparam sfp_word_t VALUE_OFFSET = 16'h0800;
	localparam sfp_word_t CRC_POLY     = 16'h1021;
	localparam int        CH_IDX_W     = 4;

	// crc-16 ccitt over one byte, msb first
	function automatic sfp_word_t crc_absorb(sfp_word_t crc, sfp_byte_t data);
		sfp_word_t c;
		c = crc ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: sv/servo_frame_parser_crc16_core.sv
// ----------------------------------------------------------------------------
// servo_frame_parser_crc16_core
// Takes one received byte per input item and one byte per clock. Hunts for
// the sync byte, collects 2*NUM_CHANNELS channel bytes and a big-endian
// crc-16 ccitt, and on a good crc sends NUM_CHANNELS channel items, one per
// clock while the output is not stalled, the last one marked. A byte reaches
// the frame logic in the cycle after acceptance; a good frame's last crc
// byte passes the input register, word buffer and result register before
// the first item. Input is held off only when a frame's last crc byte waits
// while the previous frame's items are still being sent from the word
// buffer, so with an unstalled output the block takes one byte every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_frame_parser_crc16_core import sfp_pkg::*; #(
	parameter int NUM_CHANNELS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          rx_byte,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [3:0]          channel_index,
	output logic signed [15:0]  channel_value,
	output logic                last_channel
);

	logic      match;
	logic      emit_busy;
	sfp_byte_t bytes [2*NUM_CHANNELS];

	// byte intake and crc check
	sfp_frame #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.emit_busy (emit_busy),
		.match     (match),
		.bytes     (bytes)
	);

	// channel item output
	sfp_emit #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.match         (match),
		.bytes         (bytes),
		.emit_busy     (emit_busy),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.last_channel  (last_channel)
	);

endmodule

FILE: sv/sfp_frame.sv
// ----------------------------------------------------------------------------
// sfp_frame
// input register, sync hunt, byte capture and running crc check
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfp_frame import sfp_pkg::*; #(
	parameter int NUM_CHANNELS = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  sfp_byte_t rx_byte,
	input  logic      cfg_we,
	input  sfp_word_t cfg_wdata,
	input  logic      emit_busy,
	output logic      match,
	output sfp_byte_t bytes [2*NUM_CHANNELS]
);

	localparam int DATA_BYTES = 2 * NUM_CHANNELS;
	localparam int POS_W      = $clog2(DATA_BYTES + 3);
	localparam int BIDX_W     = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
	localparam logic [POS_W-1:0] POS_HUNT    = '0;
	localparam logic [POS_W-1:0] POS_FIRST   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_DATA_HI = POS_W'(DATA_BYTES);
	localparam logic [POS_W-1:0] POS_CRC_HI  = POS_W'(DATA_BYTES + 1);
	localparam logic [POS_W-1:0] POS_CRC_LO  = POS_W'(DATA_BYTES + 2);

	logic              valid_s1;
	sfp_byte_t         byte_s1;
	logic              hold_s1;
	logic              take_s1;
	logic [POS_W-1:0]  pos_q;
	sfp_word_t         crc_q;
	sfp_word_t         crc_seed_q;
	sfp_byte_t         crc_hi_q;
	sfp_byte_t         bytes_q [DATA_BYTES];
	logic [BIDX_W-1:0] wr_idx;
	logic              in_data;

	// a completing frame waits while the previous one is still being sent
	assign hold_s1  = (pos_q == POS_CRC_LO) && emit_busy;
	assign in_stall = valid_s1 && hold_s1;
	assign take_s1  = valid_s1 && !hold_s1;
	assign in_data  = (pos_q != POS_HUNT) && (pos_q <= POS_DATA_HI);
	assign wr_idx   = BIDX_W'(pos_q - POS_FIRST);
	assign match    = take_s1 && (pos_q == POS_CRC_LO) && ({crc_hi_q, byte_s1} == crc_q);
	assign bytes    = bytes_q;

	// crc seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_seed_q <= '0;
		end else if (cfg_we) begin
			crc_seed_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// frame position and running crc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			crc_q <= '0;
		end else if (take_s1) begin
			if (pos_q == POS_HUNT) begin
				if (byte_s1 == SYNC_BYTE) begin
					pos_q <= POS_FIRST;
					crc_q <= crc_absorb(crc_seed_q, byte_s1);
				end
			end else if (in_data) begin
				pos_q <= pos_q + POS_FIRST;
				crc_q <= crc_absorb(crc_q, byte_s1);
			end else if (pos_q == POS_CRC_HI) begin
				pos_q <= pos_q + POS_FIRST;
			end else begin
				pos_q <= POS_HUNT;
			end
		end
	end

	// channel bytes and received crc high byte
	always_ff @(posedge clk) begin
		if (take_s1 && in_data) begin
			bytes_q[wr_idx] <= byte_s1;
		end
		if (take_s1 && (pos_q == POS_CRC_HI)) begin
			crc_hi_q <= byte_s1;
		end
	end

endmodule

FILE: sv/sfp_emit.sv
// ----------------------------------------------------------------------------
// sfp_emit
// channel word buffer and result register, one channel per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfp_emit import sfp_pkg::*; #(
	parameter int NUM_CHANNELS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      match,
	input  sfp_byte_t                 bytes [2*NUM_CHANNELS],
	output logic                      emit_busy,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [CH_IDX_W-1:0]       channel_index,
	output logic signed [15:0]        channel_value,
	output logic                      last_channel
);

	localparam logic [CH_IDX_W-1:0] IDX_LAST = CH_IDX_W'(NUM_CHANNELS - 1);

	logic                active_q;
	logic [CH_IDX_W-1:0] idx_q;
	sfp_word_t           words_q [NUM_CHANNELS];
	logic                load_out;
	logic                out_valid_q;
	logic [CH_IDX_W-1:0] index_q;
	sfp_word_t           value_q;
	logic                last_q;

	assign load_out      = active_q && (!out_valid_q || !out_stall);
	assign emit_busy     = active_q;
	assign out_valid     = out_valid_q;
	assign channel_index = index_q;
	assign channel_value = $signed(value_q);
	assign last_channel  = last_q;

	// emission control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (match) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (load_out) begin
				idx_q <= idx_q + CH_IDX_W'(1);
				if (idx_q == IDX_LAST) begin
					active_q <= 1'b0;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// word buffer: snapshot on a good frame, shift down per item sent
	always_ff @(posedge clk) begin
		if (match) begin
			for (int k = 0; k < NUM_CHANNELS; k++) begin
				words_q[k] <= {bytes[2*k], bytes[2*k+1]} - VALUE_OFFSET;
			end
		end else if (load_out) begin
			for (int k = 0; k < NUM_CHANNELS - 1; k++) begin
				words_q[k] <= words_q[k+1];
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			index_q <= idx_q;
			value_q <= words_q[0];
			last_q  <= (idx_q == IDX_LAST);
		end
	end

endmodule

FILE: sv/sfp_checker.sv
// ----------------------------------------------------------------------------
// sfp_checker
// port-level checks on the channel item output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "servo_frame_parser_crc16_core_assert.svh"

module sfp_checker #(
	parameter int NUM_CHANNELS = 12
) (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  channel_index,
	input logic [15:0] channel_value,
	input logic        last_channel
);

	// a stalled item holds
	`SFP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(channel_index) && $stable(channel_value) && $stable(last_channel), "stalled item changed")

	// the last mark sits on the top channel only
	`SFP_ASSERT_SAME(a_last_mark, clk, arst_n, out_valid, last_channel == (channel_index == 4'(NUM_CHANNELS - 1)), "last mark on wrong channel")

	// a frame's items follow without gaps
	`SFP_ASSERT_NEXT(a_no_gap, clk, arst_n, out_valid && !out_stall && !last_channel, out_valid, "gap inside a frame")

	// channels come in ascending order
	`SFP_ASSERT_NEXT(a_index_step, clk, arst_n, out_valid && !out_stall && !last_channel, channel_index == 4'($past(channel_index) + 4'd1), "channel order broken")

endmodule

bind servo_frame_parser_crc16_core sfp_checker #(
	.NUM_CHANNELS(NUM_CHANNELS)
) u_sfp_checker (.*);

FILE: dv/servo_frame_parser_crc16_core_tb.sv
// ----------------------------------------------------------------------------
// servo_frame_parser_crc16_core_tb
// Self-checking bench for the servo frame parser. Bytes go in one item at a
// time, with random gaps; channel items come out under random stall, and once
// under a long hold-off. A byte-level predictor of the parser builds the due
// channel items, and each channel item taken from the block is compared with
// the oldest one. A short table of directed frames comes first, with values
// typed in where they are plain, then random frames, broken frames and noise,
// with the crc seed rewritten between frames and once part way through one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_frame_parser_crc16_core_tb;
	import sfp_pkg::*;

	localparam int NUM_CHANNELS = 12;
	localparam int DATA_BYTES   = 2 * NUM_CHANNELS;
	localparam int POS_CRC_HI   = DATA_BYTES + 1;
	localparam int TOTAL_BYTES  = 450;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES  = 300;

	typedef enum logic [1:0] {
		FILL_SAME,
		FILL_RAMP,
		FILL_RAND
	} fill_t;

	typedef struct {
		bit          set_seed;
		logic [15:0] seed;
		int          junk;
		fill_t       mode;
		logic [15:0] fill;
		logic [15:0] crc_flip;
		int          split;
		logic [15:0] split_seed;
		bit          typed;
		logic [15:0] value;
	} frame_row_t;

	typedef struct {
		logic [3:0]         idx;
		logic signed [15:0] val;
		logic               last;
	} chan_result_t;

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte    = 8'h00;
	logic               cfg_we     = 1'b0;
	logic [15:0]        cfg_wdata  = 16'h0000;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [3:0]         channel_index;
	logic signed [15:0] channel_value;
	logic               last_channel;

	// predictor state
	int           frame_pos;
	logic [15:0]  run_crc;
	logic [15:0]  seed_copy;
	logic [7:0]   frame_bytes [DATA_BYTES];
	logic [7:0]   crc_hi;
	chan_result_t channels_due [$];

	// stimulus state
	logic [15:0] frame_words [NUM_CHANNELS];
	bit          typed_en;
	logic [15:0] typed_val;
	bit          quiet_sender;
	int          bytes_sent;
	int          err_count;

	// receiver state
	bit           hold_req;
	int           stall_left;
	int           mode_left;
	bit           rx_busy;
	chan_result_t due;

	// directed frames; typed values only where the word is a plain constant
	frame_row_t plan [13] = '{
		'{0, 16'h0000, 3, FILL_SAME, 16'h0800, 16'h0000, -1, 16'h0000, 1, 16'h0000},
		'{0, 16'h0000, 0, FILL_SAME, 16'h0000, 16'h0000, -1, 16'h0000, 1, 16'hF800},
		'{0, 16'h0000, 0, FILL_SAME, 16'hFFFF, 16'h0000, -1, 16'h0000, 1, 16'hF7FF},
		'{0, 16'h0000, 1, FILL_SAME, 16'h8800, 16'h0000, -1, 16'h0000, 1, 16'h8000},
		'{0, 16'h0000, 0, FILL_SAME, 16'h87FF, 16'h0000, -1, 16'h0000, 1, 16'h7FFF},
		'{0, 16'h0000, 0, FILL_SAME, 16'h1234, 16'h0001, -1, 16'h0000, 0, 16'h0000},
		'{0, 16'h0000, 0, FILL_SAME, 16'hA1A1, 16'h0000, -1, 16'h0000, 1, 16'h99A1},
		'{1, 16'hFFFF, 0, FILL_RAMP, 16'h0123, 16'h0000, -1, 16'h0000, 0, 16'h0000},
		'{1, 16'h1D0F, 2, FILL_RAND, 16'h0000, 16'h8000, -1, 16'h0000, 0, 16'h0000},
		'{0, 16'h0000, 0, FILL_RAMP, 16'hF000, 16'h0000,  9, 16'h0000, 0, 16'h0000},
		'{0, 16'h0000, 0, FILL_RAND, 16'h0000, 16'h0000, -1, 16'h0000, 0, 16'h0000},
		'{1, 16'hFFFF, 2, FILL_SAME, 16'h0800, 16'h0000, -1, 16'h0000, 1, 16'h0000},
		'{1, 16'h0000, 0, FILL_RAND, 16'h0000, 16'hFFFF, -1, 16'h0000, 0, 16'h0000}
	};

	servo_frame_parser_crc16_core #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.channel_index(channel_index),
		.channel_value(channel_value),
		.last_channel (last_channel)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// ccitt crc, one input bit at a time, msb first
	function automatic logic [15:0] ccitt_next(logic [15:0] crc, logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb  = crc[15] ^ b[i];
			crc = {crc[14:0], 1'b0};
			if (fb) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// channel words biased towards the edges of the value range
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: begin
				return 16'h0000;
			end
			1: begin
				return 16'hFFFF;
			end
			2: begin
				return VALUE_OFFSET;
			end
			3: begin
				return 16'(($urandom_range(0, 31)) + 16'h87F0);
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	function automatic logic [7:0] junk_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		while (b == SYNC_BYTE) begin
			b = 8'($urandom_range(0, 255));
		end
		return b;
	endfunction

	// parser predictor, advanced once per accepted byte
	task automatic frame_track(input logic [7:0] b);
		chan_result_t r;
		logic [15:0]  word;
		if (frame_pos == 0) begin
			if (b == SYNC_BYTE) begin
				run_crc   = ccitt_next(seed_copy, b);
				frame_pos = 1;
			end
		end else if (frame_pos <= DATA_BYTES) begin
			frame_bytes[frame_pos - 1] = b;
			run_crc   = ccitt_next(run_crc, b);
			frame_pos = frame_pos + 1;
		end else if (frame_pos == POS_CRC_HI) begin
			crc_hi    = b;
			frame_pos = frame_pos + 1;
		end else begin
			frame_pos = 0;
			if ({crc_hi, b} == run_crc) begin
				for (int k = 0; k < NUM_CHANNELS; k++) begin
					word   = {frame_bytes[2 * k], frame_bytes[2 * k + 1]};
					r.idx  = 4'(k);
					r.val  = typed_en ? typed_val : word - VALUE_OFFSET;
					r.last = (k == NUM_CHANNELS - 1);
					channels_due.push_back(r);
				end
			end
		end
	endtask

	// offer one byte item and wait for it to be taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = quiet_sender ? 0 : idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!(in_valid && !in_stall));
		frame_track(b);
		bytes_sent = bytes_sent + 1;
	endtask

	// drain all due channel items, then let the pipeline settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (channels_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(input logic [15:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		seed_copy = v;
	endtask

	// sync, channel words, crc; the seed may be rewritten part way through
	task automatic send_frame(input logic [15:0] crc_flip, input int split,
			input logic [15:0] split_seed);
		logic [7:0]  body [DATA_BYTES];
		logic [15:0] crc;
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			body[2 * k]     = frame_words[k][15:8];
			body[2 * k + 1] = frame_words[k][7:0];
		end
		crc = ccitt_next(seed_copy, SYNC_BYTE);
		for (int i = 0; i < DATA_BYTES; i++) begin
			crc = ccitt_next(crc, body[i]);
		end
		crc = crc ^ crc_flip;
		send_byte(SYNC_BYTE);
		for (int i = 0; i < DATA_BYTES; i++) begin
			if (i == split) begin
				wait_idle();
				write_seed(split_seed);
			end
			send_byte(body[i]);
		end
		send_byte(crc[15:8]);
		send_byte(crc[7:0]);
	endtask

	// receiver: check each channel item taken, then drive stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (channels_due.size() == 0) begin
				$error("channel item with none due: channel_index %0d channel_value %0d",
					channel_index, channel_value);
				err_count = err_count + 1;
			end else begin
				due = channels_due.pop_front();
				if (channel_index !== due.idx) begin
					$error("channel_index: expected %0d, got %0d", due.idx, channel_index);
					err_count = err_count + 1;
				end
				if (channel_value !== due.val) begin
					$error("channel_value: expected %0d, got %0d", due.val, channel_value);
					err_count = err_count + 1;
				end
				if (last_channel !== due.last) begin
					$error("last_channel: expected %0b, got %0b", due.last, last_channel);
					err_count = err_count + 1;
				end
			end
		end
		if (hold_req) begin
			hold_req   = 1'b0;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (mode_left == 0) begin
				mode_left = $urandom_range(20, 200);
				rx_busy   = ($urandom_range(0, 2) != 0);
			end
			mode_left = mode_left - 1;
			if (rx_busy && $urandom_range(0, 3) == 0) begin
				stall_left = idle_cycles() + 1;
			end
		end
	end

	// stimulus
	initial begin
		int          r;
		int          frames;
		logic [15:0] s;
		frame_pos    = 0;
		run_crc      = 16'h0000;
		seed_copy    = 16'h0000;
		crc_hi       = 8'h00;
		typed_en     = 1'b0;
		typed_val    = 16'h0000;
		quiet_sender = 1'b0;
		bytes_sent   = 0;
		err_count    = 0;
		hold_req     = 1'b0;
		stall_left   = 0;
		mode_left    = 0;
		rx_busy      = 1'b0;
		frames       = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames; long receiver hold-off at the start, so the
		// second frame backs up behind the first
		hold_req = 1'b1;
		foreach (plan[i]) begin
			if (plan[i].set_seed) begin
				wait_idle();
				write_seed(plan[i].seed);
			end
			quiet_sender = ($urandom_range(0, 2) == 0);
			repeat (plan[i].junk) send_byte(junk_byte());
			for (int k = 0; k < NUM_CHANNELS; k++) begin
				case (plan[i].mode)
					FILL_SAME: begin
						frame_words[k] = plan[i].fill;
					end
					FILL_RAMP: begin
						frame_words[k] = plan[i].fill + 16'(k) * 16'h1111;
					end
					default: begin
						frame_words[k] = pick_word();
					end
				endcase
			end
			typed_en  = plan[i].typed;
			typed_val = plan[i].value;
			send_frame(plan[i].crc_flip, plan[i].split, plan[i].split_seed);
			typed_en  = 1'b0;
		end
		wait_idle();

		// random frames, broken frames and noise up to the total byte count
		while (bytes_sent < TOTAL_BYTES) begin
			frames = frames + 1;
			if (frames % 6 == 0) begin
				wait_idle();
				case ($urandom_range(0, 3))
					0: begin
						s = 16'h0000;
					end
					1: begin
						s = 16'hFFFF;
					end
					default: begin
						s = 16'($urandom);
					end
				endcase
				write_seed(s);
			end
			quiet_sender = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 82) begin
				repeat ($urandom_range(0, 2)) send_byte(junk_byte());
				for (int k = 0; k < NUM_CHANNELS; k++) begin
					frame_words[k] = pick_word();
				end
				if (r < 70) begin
					send_frame(16'h0000, -1, 16'h0000);
				end else begin
					send_frame(16'($urandom_range(1, 65535)), -1, 16'h0000);
				end
			end else if (r < 90) begin
				// noise, possibly starting a frame of its own
				repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				// cut-off frame; what follows is taken as its data
				send_byte(SYNC_BYTE);
				repeat ($urandom_range(1, DATA_BYTES + 1)) send_byte(8'($urandom_range(0, 255)));
			end
		end

		wait_idle();
		if (err_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
